// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk_i, off while in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SSM_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define SSM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/core/ssm_pkg.sv -----
// ----------------------------------------------------------------------------
// ssm_pkg
// shared widths, codes and types of the stepper stall monitor
// ----------------------------------------------------------------------------
package ssm_pkg;

  // default half-pulse counter width
  localparam int PULSE_CNT_W_DEF = 24;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int LIMIT_W    = 8;

  // field widths
  localparam int FUNC_W = 2;
  localparam int POS_W  = 32;

  // width of |diff| + threshold + 1, always below 2^32
  localparam int SUM_W = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_STEP  = 2'd0,
    FUNC_CHECK = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENC_RES   = 3'd0,
    REG_MOT_RES   = 3'd1,
    REG_THRESHOLD = 3'd2,
    REG_LIMIT     = 3'd3,
    REG_DUMMY     = 3'd4
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIFF  = 5'b00010,
    ST_SUM   = 5'b00100,
    ST_MUL   = 5'b01000,
    ST_WRITE = 5'b10000
  } state_e;

endpackage

// ----- rtl/core/stepper_stall_monitor.sv -----
// ----------------------------------------------------------------------------
// stepper_stall_monitor
// step generator and stall detector for one stepper axis
//
// input channel (in_valid_i/in_ready_o) takes one word: func_i and
// encoder_position_i. func 0 toggles the step level and counts a half pulse,
// func 1 checks for a stall against the encoder, func 2 clears the stall flag.
// output channel (out_valid_o/out_ready_i) gives one word per input word:
// stall_detected_o, stalled_o and step_level_o as they stand after the item.
// a step, clear or ignored word, or a check on a dummy axis, goes straight to
// the commit state. a check steps through the encoder difference, then
// |diff| + threshold + 1, then a bit-serial multiplier that shifts one bit
// of encoder and motor resolution per cycle, then the commit.
// short test: pulse_pairs*enc_res >= (|diff|+threshold+1)*mot_res, no divider
// one word is in flight at a time; a new word is taken as soon as the
// engine is idle, even while the previous result waits in the output
// register. a stalled receiver holds the finished word in the commit state.
// reset is asynchronous active low: config returns to 1,1,0,1,0 and all
// counters, flags and the step level clear. config writes (cfg_we_i) take
// effect at once. the user must issue them only while idle; no logic checks it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stepper_stall_monitor #(
  parameter int PULSE_COUNT_WIDTH = ssm_pkg::PULSE_CNT_W_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [ssm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ssm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input words
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ssm_pkg::FUNC_W-1:0]     func_i,
  input  logic signed [ssm_pkg::POS_W-1:0] encoder_position_i,
  // result words
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           stall_detected_o,
  output logic                           stalled_o,
  output logic                           step_level_o
);

  import ssm_pkg::*;

  localparam int PW    = PULSE_COUNT_WIDTH;
  localparam int HW    = PW - 1;
  // widest multiplicand, pulse-pair count or the compare sum
  localparam int OpW   = (HW > SUM_W) ? HW : SUM_W;
  // signed difference of two OpW x CFG_DATA_W products
  localparam int AccW  = OpW + CFG_DATA_W + 1;
  localparam int CntW  = $clog2(CFG_DATA_W);

  // configuration registers
  logic [CFG_DATA_W-1:0] enc_res_q, mot_res_q, thr_q;
  logic [LIMIT_W-1:0]    limit_q;
  logic                  dummy_q;

  // axis state
  logic [PW-1:0]         pulses_q, pulses_d;
  logic [POS_W-1:0]      last_q, last_d;
  logic [LIMIT_W-1:0]    short_q, short_d;
  logic                  stall_q, stall_d;
  logic                  step_q, step_d;

  // engine
  state_e                state_q, state_d;
  logic [FUNC_W-1:0]     func_q;
  logic [POS_W-1:0]      pos_q;
  logic [POS_W-1:0]      diff_q;
  logic [SUM_W-1:0]      sum_q;
  logic [CFG_DATA_W-1:0] enc_sh_q, mot_sh_q;
  logic [AccW-1:0]       acc_q, acc_d;
  logic [CntW-1:0]       cnt_q;

  // output register
  logic                  out_valid_q;
  logic                  det_q, stalled_q, level_q;

  logic                  commit;
  logic                  det_d;
  logic                  is_short;
  logic                  diff_neg;
  logic [SUM_W-1:0]      sum_d;
  logic [LIMIT_W-1:0]    short_inc;

  assign in_ready_o = (state_q == ST_IDLE);
  assign commit     = (state_q == ST_WRITE) && (!out_valid_q || out_ready_i);

  // sign of the accumulator decides the short test
  assign is_short   = !acc_q[AccW-1];
  assign short_inc  = short_q + LIMIT_W'(1);

  // |diff| + threshold + 1 in one add: for negative diff, ~diff + 1 is the magnitude
  assign diff_neg   = diff_q[POS_W-1];
  assign sum_d      = (diff_neg ? ~diff_q : diff_q) + SUM_W'(thr_q)
                    + (diff_neg ? SUM_W'(2) : SUM_W'(1));

  // msb-first shift-add: acc = 2*acc + e_bit*H - m_bit*S
  assign acc_d = {acc_q[AccW-2:0], 1'b0}
               + (enc_sh_q[CFG_DATA_W-1] ? AccW'(pulses_q[PW-1:1]) : AccW'(0))
               - (mot_sh_q[CFG_DATA_W-1] ? AccW'(sum_q) : AccW'(0));

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (func_i == FUNC_CHECK && !dummy_q) begin
            state_d = ST_DIFF;
          end else begin
            state_d = ST_WRITE;
          end
        end
      end
      ST_DIFF:  state_d = ST_SUM;
      ST_SUM:   state_d = ST_MUL;
      ST_MUL: begin
        if (cnt_q == CntW'(CFG_DATA_W - 1)) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // state update at commit
  always_comb begin
    pulses_d = pulses_q;
    last_d   = last_q;
    short_d  = short_q;
    stall_d  = stall_q;
    step_d   = step_q;
    det_d    = 1'b0;
    case (func_q)
      FUNC_STEP: begin
        if (!dummy_q) begin
          if (pulses_q != '1) begin
            pulses_d = pulses_q + PW'(1);
          end
          step_d = !step_q;
        end
      end
      FUNC_CHECK: begin
        if (!dummy_q) begin
          if (is_short && short_inc >= limit_q) begin
            // stall declared: pulse count and position are kept
            short_d = '0;
            stall_d = 1'b1;
            det_d   = 1'b1;
          end else begin
            short_d  = is_short ? short_inc : '0;
            pulses_d = '0;
            last_d   = pos_q;
          end
        end
      end
      FUNC_CLEAR: begin
        stall_d = 1'b0;
        short_d = '0;
      end
      default: begin
        // unused code, state unchanged
      end
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      enc_res_q   <= CFG_DATA_W'(1);
      mot_res_q   <= CFG_DATA_W'(1);
      thr_q       <= '0;
      limit_q     <= LIMIT_W'(1);
      dummy_q     <= 1'b0;
      pulses_q    <= '0;
      last_q      <= '0;
      short_q     <= '0;
      stall_q     <= 1'b0;
      step_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (state_q == ST_MUL) begin
        cnt_q <= cnt_q + CntW'(1);
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ENC_RES:   enc_res_q <= cfg_data_i;
          REG_MOT_RES:   mot_res_q <= cfg_data_i;
          REG_THRESHOLD: thr_q     <= cfg_data_i;
          REG_LIMIT:     limit_q   <= cfg_data_i[LIMIT_W-1:0];
          REG_DUMMY:     dummy_q   <= cfg_data_i[0];
          default: begin
            // no register at this index
          end
        endcase
      end

      if (commit) begin
        pulses_q    <= pulses_d;
        last_q      <= last_d;
        short_q     <= short_d;
        stall_q     <= stall_d;
        step_q      <= step_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q <= func_i;
      pos_q  <= encoder_position_i;
    end
    if (state_q == ST_DIFF) begin
      diff_q <= pos_q - last_q;
    end
    if (state_q == ST_SUM) begin
      sum_q    <= sum_d;
      enc_sh_q <= enc_res_q;
      // zero motor resolution counts as one
      mot_sh_q <= (mot_res_q == '0) ? CFG_DATA_W'(1) : mot_res_q;
      acc_q    <= '0;
    end
    if (state_q == ST_MUL) begin
      acc_q    <= acc_d;
      enc_sh_q <= {enc_sh_q[CFG_DATA_W-2:0], 1'b0};
      mot_sh_q <= {mot_sh_q[CFG_DATA_W-2:0], 1'b0};
    end
    if (commit) begin
      det_q     <= det_d;
      stalled_q <= stall_d;
      level_q   <= step_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stall_detected_o = det_q;
  assign stalled_o        = stalled_q;
  assign step_level_o     = level_q;

  // a declared stall always leaves the sticky flag set
  `SSM_ASSERT_IMPL(a_det_sets_flag, out_valid_o && stall_detected_o, stalled_o)
  // declaring a stall restarts the shortfall count
  `SSM_ASSERT_NEXT(a_stall_clears_short, commit && det_d, stall_q && short_q == '0)
  // a dummy axis never moves the step output
  `SSM_ASSERT_NEXT(a_dummy_holds_step, commit && dummy_q, step_q == $past(step_q))
  // bit counter only runs inside the multiply
  `SSM_ASSERT_IMPL(a_cnt_idle, state_q != ST_MUL, cnt_q == '0)

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the stepper stall monitor
//
// a behavioral copy of the axis (half-pulse count, stored position, shortfall
// count, sticky stall flag, step level) predicts the status word of every
// accepted input word. a checker compares each result word field by field
// with the oldest prediction. directed tests cover extremes and corner cases,
// then random bursts of steps followed by shaped checks run under several
// register settings, with random idling and backpressure on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import ssm_pkg::*;

  // narrow pulse counter so saturation is reachable in a short run
  localparam int PULSE_W      = 8;
  localparam int WATCHDOG     = 2000;
  localparam int SETTLE_WAIT  = 40;
  localparam int HOLD_OFF     = 400;
  localparam int PHASE_WORDS  = 40;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // status word of one result
  typedef struct packed {
    logic detected;
    logic stalled;
    logic level;
  } status_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [FUNC_W-1:0]     func_i = '0;
  logic signed [POS_W-1:0] encoder_position_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  stall_detected_o;
  logic                  stalled_o;
  logic                  step_level_o;

  // register copies
  logic [15:0] enc_res;
  logic [15:0] mot_res;
  logic [15:0] thr;
  logic [7:0]  stall_lim;
  logic        dummy;

  // axis state copies
  logic [PULSE_W-1:0] pulse_cnt;
  logic [31:0]        stored_pos;
  logic [7:0]         short_cnt;
  logic               stall_flag;
  logic               step_out;

  status_t status_q[$];
  int      mismatch_cnt = 0;
  int      live_words = 0;
  int      idle_cycles = 0;
  int      hold_len = 0;
  int      hold_left = 0;
  bit      quiet = 1'b0;

  stepper_stall_monitor #(
    .PULSE_COUNT_WIDTH(PULSE_W)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .func_i             (func_i),
    .encoder_position_i (encoder_position_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .stall_detected_o   (stall_detected_o),
    .stalled_o          (stalled_o),
    .step_level_o       (step_level_o)
  );

  always #2 clk_i = ~clk_i;

  // expected travel since the last stored position, may go negative
  function automatic longint expected_travel();
    longint unsigned quot;
    longint unsigned div;
    div  = (mot_res == 16'd0) ? 64'd1 : 64'(mot_res);
    quot = (64'(pulse_cnt >> 1) * 64'(enc_res)) / div;
    return longint'(quot) - longint'(64'(thr));
  endfunction

  // advance the axis copy by one word and give the status it leaves
  task automatic advance_axis(input logic [FUNC_W-1:0] f, input logic [31:0] pos,
                              output status_t s);
    logic [31:0] delta;
    logic [31:0] mag;
    logic        hit;
    hit = 1'b0;
    case (f)
      FUNC_STEP: begin
        if (!dummy) begin
          // count saturates, level still toggles
          if (pulse_cnt != '1) pulse_cnt = pulse_cnt + 1'b1;
          step_out = ~step_out;
        end
      end
      FUNC_CHECK: begin
        if (!dummy) begin
          delta = pos - stored_pos;
          // most negative change gives 2^31 as unsigned magnitude
          mag = delta[31] ? (32'd0 - delta) : delta;
          if (longint'({32'd0, mag}) < expected_travel()) begin
            short_cnt = short_cnt + 8'd1;
            if (short_cnt >= stall_lim) begin
              short_cnt  = 8'd0;
              stall_flag = 1'b1;
              hit        = 1'b1;
            end
          end else begin
            short_cnt = 8'd0;
          end
          // a declared stall keeps the count and the stored position
          if (!hit) begin
            pulse_cnt  = '0;
            stored_pos = pos;
          end
        end
      end
      FUNC_CLEAR: begin
        stall_flag = 1'b0;
        short_cnt  = 8'd0;
      end
      default: begin
      end
    endcase
    s = '{detected: hit, stalled: stall_flag, level: step_out};
  endtask

  // one register write, taken at the next rising edge
  task automatic write_reg(input reg_idx_e idx, input logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    case (idx)
      REG_ENC_RES:   enc_res   = v;
      REG_MOT_RES:   mot_res   = v;
      REG_THRESHOLD: thr       = v;
      REG_LIMIT:     stall_lim = v[7:0];
      REG_DUMMY:     dummy     = v[0];
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(input logic [15:0] enc, input logic [15:0] mot,
                           input logic [15:0] th, input logic [7:0] lim,
                           input logic dum);
    write_reg(REG_ENC_RES, enc);
    write_reg(REG_MOT_RES, mot);
    write_reg(REG_THRESHOLD, th);
    write_reg(REG_LIMIT, {8'd0, lim});
    write_reg(REG_DUMMY, {15'd0, dum});
  endtask

  // offer one word, keep it up until taken, then record the prediction
  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [31:0] pos);
    status_t s;
    int      gap;
    @(negedge clk_i);
    if (!quiet && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(5, 1);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    func_i             <= f;
    encoder_position_i <= pos;
    do @(posedge clk_i); while (!in_ready_o);
    if (f != FUNC_UNUSED && (!dummy || f == FUNC_CLEAR)) live_words++;
    advance_axis(f, pos, s);
    status_q.push_back(s);
  endtask

  // sender goes quiet until every result has come back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // check with a position shaped around the expected travel
  task automatic send_check();
    longint      travel;
    logic [31:0] mag;
    logic [31:0] pos;
    int          kind;
    travel = expected_travel();
    kind   = $urandom_range(9);
    if (kind < 4 && travel > 0) begin
      mag = $urandom_range(32'(travel - 1), 0);
    end else if (kind < 8) begin
      mag = ((travel > 0) ? 32'(travel) : 32'd0) + $urandom_range(3, 0);
    end else begin
      mag = $urandom();
    end
    if (kind >= 8) pos = $urandom();
    else pos = $urandom_range(1) ? stored_pos - mag : stored_pos + mag;
    send_word(FUNC_CHECK, pos);
  endtask

  // a run of half pulses followed by one closing word
  task automatic random_burst();
    int n;
    int r;
    n = $urandom_range(24, 0);
    repeat (n) send_word(FUNC_STEP, $urandom());
    r = $urandom_range(99);
    if (r < 5) send_word(FUNC_CLEAR, $urandom());
    else if (r < 8) send_word(FUNC_UNUSED, $urandom());
    else send_check();
  endtask

  task automatic run_phase(input int words);
    int start;
    start = live_words;
    while (live_words - start < words) random_burst();
    drain_results();
  endtask

  // ---------------------------------------------------------------- tests

  // state right after reset: clear, unused code, check at zero
  task automatic test_reset_state();
    send_word(FUNC_CLEAR, 32'hFFFF_FFFF);
    send_word(FUNC_UNUSED, 32'h0000_0000);
    send_word(FUNC_CHECK, 32'h0000_0000);
    drain_results();
  endtask

  // extremes of position, zero divisor, zero limit, negative travel, dummy axis
  task automatic test_corner_cases();
    // default setting: short check at limit one stalls and keeps the position
    repeat (4) send_word(FUNC_STEP, 32'h5555_5555);
    send_word(FUNC_CHECK, 32'h0000_0001);
    send_word(FUNC_CLEAR, 32'hAAAA_AAAA);
    // most negative change, then a wrap across the sign boundary
    send_word(FUNC_CHECK, 32'h8000_0000);
    send_word(FUNC_CHECK, 32'h7FFF_FFFF);
    send_word(FUNC_CHECK, 32'hFFFF_FFFF);
    send_word(FUNC_UNUSED, 32'hFFFF_FFFF);
    drain_results();

    // zero divisor and zero limit: first short check stalls at once
    write_all(16'hFFFF, 16'h0000, 16'hFFFF, 8'd0, 1'b0);
    repeat (4) send_word(FUNC_STEP, 32'h0);
    send_word(FUNC_CHECK, stored_pos + 32'd10);
    drain_results();

    // threshold larger than travel: never short
    write_all(16'h0001, 16'hFFFF, 16'hFFFF, 8'd2, 1'b0);
    send_word(FUNC_CLEAR, 32'h0);
    repeat (2) send_word(FUNC_STEP, 32'h0);
    send_word(FUNC_CHECK, stored_pos);
    drain_results();

    // limit two: second short in a row declares the stall
    write_all(16'h0010, 16'h0001, 16'h0000, 8'd2, 1'b0);
    repeat (2) begin
      repeat (2) send_word(FUNC_STEP, 32'h0);
      send_word(FUNC_CHECK, stored_pos + 32'd3);
    end
    drain_results();

    // dummy axis ignores steps and checks, a clear still acts
    write_reg(REG_DUMMY, 16'd1);
    send_word(FUNC_STEP, 32'h0);
    send_word(FUNC_CHECK, 32'h1234_5678);
    send_word(FUNC_CLEAR, 32'h0);
    drain_results();
  endtask

  // pulse count saturates while the level keeps toggling
  task automatic test_pulse_saturation();
    write_all(16'h0001, 16'h0001, 16'h0000, 8'd3, 1'b0);
    quiet = 1'b1;
    repeat ((1 << PULSE_W) + 4) send_word(FUNC_STEP, $urandom());
    quiet = 1'b0;
    send_word(FUNC_CHECK, stored_pos);
    send_word(FUNC_CHECK, stored_pos + 32'd1);
    drain_results();
  endtask

  // receiver holds off long enough that the input stalls, then full drain
  task automatic test_backpressure();
    hold_len = HOLD_OFF;
    repeat (3) random_burst();
    drain_results();
    repeat (4) random_burst();
    drain_results();
  endtask

  // random bursts under several register settings
  task automatic test_random_traffic();
    write_all(16'hFFFF, 16'hFFFF, 16'h0000, 8'd1, 1'b0);
    run_phase(PHASE_WORDS);
    write_all(16'h0001, 16'h0001, 16'h0000, 8'd255, 1'b0);
    run_phase(PHASE_WORDS);
    write_all(16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
              16'($urandom_range(64, 0)), 8'($urandom_range(4, 1)), 1'b0);
    run_phase(PHASE_WORDS);
    // dummy axis: mostly ignored words, a fixed number of bursts
    write_reg(REG_DUMMY, 16'd1);
    repeat (4) random_burst();
    drain_results();
    // stretch with no idling on either side
    quiet = 1'b1;
    write_all(16'($urandom_range(65535, 1)), 16'($urandom_range(16, 1)),
              16'($urandom_range(255, 0)), 8'($urandom_range(3, 1)), 1'b0);
    run_phase(PHASE_WORDS);
    quiet = 1'b0;
    write_all(16'hFFFF, 16'h0001, 16'hFFFF, 8'd2, 1'b0);
    run_phase(PHASE_WORDS);
    write_all(16'($urandom_range(65535, 0)), 16'h0000,
              16'($urandom_range(65535, 0)), 8'd0, 1'b0);
    run_phase(PHASE_WORDS);
  endtask

  // ------------------------------------------------------------ processes

  // receiver: random stalls, or a long hold-off counted here
  always @(negedge clk_i) begin
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len  = 0;
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (!quiet && $urandom_range(99) < 23) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic report_word(input string what, input status_t want, input status_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t %s: expected det=%0b stl=%0b lvl=%0b, got det=%0b stl=%0b lvl=%0b",
               $realtime, what, want.detected, want.stalled, want.level,
               got.detected, got.stalled, got.level);
  endtask

  // result checker
  always @(posedge clk_i) begin
    status_t want;
    status_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{detected: stall_detected_o, stalled: stalled_o, level: step_level_o};
      if (status_q.size() == 0) begin
        report_word("word with nothing expected", '0, got);
      end else begin
        want = status_q.pop_front();
        if (got.detected !== want.detected || got.stalled !== want.stalled ||
            got.level !== want.level)
          report_word("status mismatch", want, got);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("FAIL stepper_stall_monitor");
      $finish;
    end
  end

  initial begin
    enc_res    = 16'd1;
    mot_res    = 16'd1;
    thr        = 16'd0;
    stall_lim  = 8'd1;
    dummy      = 1'b0;
    pulse_cnt  = '0;
    stored_pos = '0;
    short_cnt  = '0;
    stall_flag = 1'b0;
    step_out   = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_corner_cases();
    test_pulse_saturation();
    test_backpressure();
    test_random_traffic();

    drain_results();
    repeat (SETTLE_WAIT) @(posedge clk_i);
    if (mismatch_cnt == 0 && status_q.size() == 0) begin
      $display("PASS stepper_stall_monitor");
    end else begin
      $display("FAIL stepper_stall_monitor");
    end
    $finish;
  end

endmodule
